[rtl/bavg_pkg.sv]
// ----------------------------------------------------------------------------
// bavg_pkg
// shared widths, register indexes and the position record of the
// box average downsampler
// ----------------------------------------------------------------------------
package bavg_pkg;

  localparam int PIX_W     = 8;
  localparam int FACTOR_W  = 5;
  localparam int SIDE_W    = 13;
  localparam int LIM_W     = SIDE_W + 1;
  localparam int MAX_SIDE  = 4096;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_OUT_COLS = 4096;
  localparam int DEF_MAX_FACTOR   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACTOR  = 2'd0,
    REG_IN_COLS = 2'd1,
    REG_IN_ROWS = 2'd2,
    REG_NONE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic active;
    logic first;
    logic emit;
    logic row_end;
    logic image_end;
  } pos_info_t;

endpackage

[rtl/bavg_ram.sv]
// ----------------------------------------------------------------------------
// bavg_ram
// column sum store, one write and one registered read port
// ----------------------------------------------------------------------------
module bavg_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/bavg_pos.sv]
// ----------------------------------------------------------------------------
// bavg_pos
// configuration registers and source position tracking: decides per pixel
// whether it lies in a full block, opens or closes a block, ends the image or a row
// ----------------------------------------------------------------------------
module bavg_pos #(
  parameter int MAX_OUT_COLS = bavg_pkg::DEF_MAX_OUT_COLS,
  parameter int MAX_FACTOR   = bavg_pkg::DEF_MAX_FACTOR
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr,
  input  logic [bavg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bavg_pkg::SIDE_W-1:0]       cfg_data,
  input  logic                              step,
  output logic [bavg_pkg::FACTOR_W-1:0]     factor,
  output bavg_pkg::pos_info_t               info,
  output logic [$clog2(MAX_OUT_COLS)-1:0]   addr
);

  import bavg_pkg::*;

  localparam int AW = $clog2(MAX_OUT_COLS);

  logic [SIDE_W-1:0]   cols;
  logic [SIDE_W-1:0]   rows;
  logic [SIDE_W-1:0]   src_col;
  logic [SIDE_W-1:0]   src_row;
  logic [SIDE_W-1:0]   out_col;
  logic [FACTOR_W-1:0] phase_col;
  logic [FACTOR_W-1:0] phase_row;
  logic [LIM_W-1:0]    col_lim;
  logic [LIM_W-1:0]    row_lim;

  logic [FACTOR_W-1:0] factor_wr;
  logic [SIDE_W-1:0]   side_wr;
  logic [FACTOR_W-1:0] factor_next;
  logic [FACTOR_W-1:0] phase_col_inc;
  logic [LIM_W-1:0]    col_lim_step;
  logic [LIM_W-1:0]    row_lim_step;
  logic                valid_index;

  always_comb begin
    if (cfg_data[FACTOR_W-1:0] == '0) begin
      factor_wr = FACTOR_W'(1);
    end else if (32'(cfg_data[FACTOR_W-1:0]) > MAX_FACTOR) begin
      factor_wr = FACTOR_W'(MAX_FACTOR);
    end else begin
      factor_wr = cfg_data[FACTOR_W-1:0];
    end
    if (cfg_data == '0) begin
      side_wr = SIDE_W'(1);
    end else if (32'(cfg_data) > MAX_SIDE) begin
      side_wr = SIDE_W'(MAX_SIDE);
    end else begin
      side_wr = cfg_data;
    end
  end

  assign valid_index = (cfg_index == REG_FACTOR) || (cfg_index == REG_IN_COLS)
                    || (cfg_index == REG_IN_ROWS);
  assign factor_next = (cfg_index == REG_FACTOR) ? factor_wr : factor;

  assign phase_col_inc = phase_col + FACTOR_W'(1);
  assign col_lim_step  = col_lim + LIM_W'(factor);
  assign row_lim_step  = row_lim + LIM_W'(factor);

  always_comb begin
    info.active    = (32'(out_col) < MAX_OUT_COLS) && (col_lim <= LIM_W'(cols))
                  && (row_lim <= LIM_W'(rows));
    info.first     = (phase_col == '0) && (phase_row == '0);
    info.emit      = (phase_col == factor - FACTOR_W'(1))
                  && (phase_row == factor - FACTOR_W'(1));
    info.row_end   = (32'(out_col) == MAX_OUT_COLS - 1) || (col_lim_step > LIM_W'(cols));
    info.image_end = info.row_end && (row_lim_step > LIM_W'(rows));
  end

  assign addr = AW'(out_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      factor    <= FACTOR_W'(1);
      cols      <= SIDE_W'(1);
      rows      <= SIDE_W'(1);
      src_col   <= '0;
      src_row   <= '0;
      out_col   <= '0;
      phase_col <= '0;
      phase_row <= '0;
      col_lim   <= LIM_W'(1);
      row_lim   <= LIM_W'(1);
    end else if (cfg_wr && valid_index) begin
      unique case (cfg_index)
        REG_FACTOR:  factor <= factor_wr;
        REG_IN_COLS: cols   <= side_wr;
        REG_IN_ROWS: rows   <= side_wr;
        default: ;
      endcase
      src_col   <= '0;
      src_row   <= '0;
      out_col   <= '0;
      phase_col <= '0;
      phase_row <= '0;
      col_lim   <= LIM_W'(factor_next);
      row_lim   <= LIM_W'(factor_next);
    end else if (step) begin
      if (src_col >= cols - SIDE_W'(1)) begin
        src_col   <= '0;
        out_col   <= '0;
        phase_col <= '0;
        col_lim   <= LIM_W'(factor);
        if (src_row >= rows - SIDE_W'(1)) begin
          src_row   <= '0;
          phase_row <= '0;
          row_lim   <= LIM_W'(factor);
        end else begin
          src_row <= src_row + SIDE_W'(1);
          if (phase_row >= factor - FACTOR_W'(1)) begin
            phase_row <= '0;
            row_lim   <= row_lim_step;
          end else begin
            phase_row <= phase_row + FACTOR_W'(1);
          end
        end
      end else begin
        src_col <= src_col + SIDE_W'(1);
        if (phase_col_inc >= factor) begin
          phase_col <= '0;
          if (32'(out_col) < MAX_SIDE) begin
            out_col <= out_col + SIDE_W'(1);
            col_lim <= col_lim_step;
          end
        end else begin
          phase_col <= phase_col_inc;
        end
      end
    end
  end

endmodule

[rtl/bavg_div.sv]
// ----------------------------------------------------------------------------
// bavg_div
// rounded block mean, (2*sum + n) / (2*n) with n = factor squared, by
// restoring division one quotient bit per cycle
// ----------------------------------------------------------------------------
module bavg_div #(
  parameter int SUM_W = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SUM_W-1:0]              sum,
  input  logic [bavg_pkg::FACTOR_W-1:0] factor,
  input  logic                          take,
  output logic                          busy,
  output logic                          valid,
  output logic [bavg_pkg::PIX_W-1:0]    quot
);

  import bavg_pkg::*;

  localparam int DW = SUM_W + 2;
  localparam int CW = $clog2(PIX_W);

  logic [2*FACTOR_W-1:0] n;
  logic [DW-1:0]         rem;
  logic [DW-1:0]         dsh;
  logic [CW-1:0]         cnt;
  logic                  fits;

  assign n    = factor * factor;
  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      valid <= 1'b0;
    end else if (busy) begin
      if (cnt == CW'(PIX_W - 1)) begin
        busy  <= 1'b0;
        valid <= 1'b1;
      end
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, sum, 1'b0} + DW'(n);
      dsh  <= DW'(n) << PIX_W;
      cnt  <= '0;
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[PIX_W-2:0], fits};
      dsh  <= dsh >> 1;
      cnt  <= cnt + CW'(1);
    end
  end

endmodule

[rtl/box_average_downsample_unit.sv]
// ----------------------------------------------------------------------------
// box_average_downsample_unit
// downsamples an 8-bit raster stream by averaging factor x factor blocks,
// partial block sums held per output column in a synchronous memory
//
//   channel   dir  beat contents
//   s_axis    in   tdata[7:0] pixel
//   m_axis    out  tdata[7:0] avg_pixel, tlast row_end, tuser image_end
//   cfg       in   cfg_index register, cfg_data value (0 factor, 1 cols, 2 rows)
//
// a pixel is accepted with memory read in S_IDLE, then added and written back in S_UPD
// the pixel closing a block then goes through 8 divider steps and the output load
// one result waits in the output register while further pixels are taken
// a closing pixel waits in the divider until the output register is free
// synchronous reset clears counters, configuration and valid flags, not the column sums
// ----------------------------------------------------------------------------
module box_average_downsample_unit #(
  parameter int MAX_OUT_COLS = bavg_pkg::DEF_MAX_OUT_COLS,
  parameter int MAX_FACTOR   = bavg_pkg::DEF_MAX_FACTOR
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bavg_pkg::PIX_W-1:0]     s_axis_tdata,   // pixel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bavg_pkg::PIX_W-1:0]     m_axis_tdata,   // avg_pixel
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser,   // image_end
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bavg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bavg_pkg::SIDE_W-1:0]    cfg_data
);

  import bavg_pkg::*;

  localparam int AW    = $clog2(MAX_OUT_COLS);
  localparam int SUM_W = PIX_W + 2 * $clog2(MAX_FACTOR);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV
  } state_t;

  state_t state;

  logic                accept;
  logic [FACTOR_W-1:0] factor;
  pos_info_t           info;
  logic [AW-1:0]       addr;
  pos_info_t           info_q;
  logic [AW-1:0]       addr_q;
  logic [PIX_W-1:0]    px_q;
  logic [SUM_W-1:0]    rd_sum;
  logic [SUM_W-1:0]    sum_new;
  logic                wr_en;
  logic                div_start;
  logic                div_take;
  logic                div_busy;
  logic                div_valid;
  logic [PIX_W-1:0]    div_quot;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bavg_pos #(
    .MAX_OUT_COLS (MAX_OUT_COLS),
    .MAX_FACTOR   (MAX_FACTOR)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .factor    (factor),
    .info      (info),
    .addr      (addr)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      px_q   <= s_axis_tdata;
      info_q <= info;
      addr_q <= addr;
    end
  end

  bavg_ram #(
    .DEPTH (MAX_OUT_COLS),
    .WIDTH (SUM_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (addr),
    .rd_data (rd_sum),
    .wr_en   (wr_en),
    .wr_addr (addr_q),
    .wr_data (sum_new)
  );

  assign sum_new   = info_q.first ? SUM_W'(px_q) : rd_sum + SUM_W'(px_q);
  assign wr_en     = (state == S_UPD) && info_q.active;
  assign div_start = wr_en && info_q.emit;
  assign div_take  = (state == S_DIV) && div_valid && (!m_axis_tvalid || m_axis_tready);

  bavg_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .sum    (sum_new),
    .factor (factor),
    .take   (div_take),
    .busy   (div_busy),
    .valid  (div_valid),
    .quot   (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !div_take) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          state <= div_start ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_take) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= div_quot;
            m_axis_tlast  <= info_q.row_end;
            m_axis_tuser  <= info_q.image_end;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_pixel_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("pixel accepted during read-modify-write");

  a_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(accept))
    else $error("column sum written without a preceding read");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy && !div_valid)
    else $error("divider started while holding a result");

  a_image_end_ends_row: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("image end without row end");
`endif

endmodule
